[rtl/core/knap_pkg.sv]
// Shared types and constants of the 0/1 knapsack best-value solver.
// No dependencies; imported by the solver core, its checker and the testbench.
package knap_pkg;

    localparam int WGT_W = 16;
    localparam int VAL_W = 16;
    localparam int RES_W = 32;
    localparam int CAP_W = 10;
    localparam int CMP_W = 17;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    // Register index, taken from paddr[2]
    localparam logic REG_CAPACITY = 1'b0;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN
    } t_state;

endpackage

[rtl/core/knapsack_01_best_value.sv]
// 0/1 knapsack solver: a single row of best values, one per capacity, in a synchronous memory.
// Depends on knap_pkg.
//
// Use: items arrive on the input channel (i_in_valid / o_in_stall) with a weight,
// a value and a last flag. Each request sweeps the whole row from the top
// capacity down to zero, one entry per cycle: read best[j] and best[j-w], write
// the larger of best[j] and best[j-w]+v (saturating at 2^32-1) back to best[j].
// Each item is accepted in the idle state, swept through the memory's single
// write port and followed by a drain state for the last write-back, with the input
// stalled throughout. On a last item the entry at the configured capacity (clamped to
// MAX_CAPACITY) is sent on the output channel (o_out_valid / i_out_stall) during
// that sweep, and the sweep writes zeros so that the row is clear for the next set.
// The result register holds while the receiver stalls; non-last items are still
// taken meanwhile, but a last item waits until the pending result is gone.
// After reset a clearing pass zeroes the row; the input stalls during that pass
// while APB writes are taken as usual.
// capacity sits at byte address 0 of the APB port; pready is always high.
module knapsack_01_best_value #(
    parameter int MAX_CAPACITY = 1023
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [knap_pkg::WGT_W-1:0]  i_item_weight,
    input  logic [knap_pkg::VAL_W-1:0]  i_item_value,
    input  logic                        i_last_item,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [knap_pkg::RES_W-1:0]  o_best_value,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [knap_pkg::ADDR_W-1:0] paddr,
    input  logic [knap_pkg::DATA_W-1:0] pwdata,
    output logic [knap_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import knap_pkg::*;

    localparam int ROW_LEN = MAX_CAPACITY + 1;
    localparam int IW = $clog2(ROW_LEN);
    localparam logic [IW-1:0] MAX_IDX = IW'(MAX_CAPACITY);
    localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_CAPACITY);

    logic [RES_W-1:0] mem [ROW_LEN];

    t_state r_state, n_state;
    logic [IW-1:0] r_idx;
    logic [CAP_W-1:0] r_cap;
    logic [WGT_W-1:0] r_w;
    logic [VAL_W-1:0] r_v;
    logic r_last;
    logic r_s1_vld;
    logic [IW-1:0] r_s1_idx;
    logic r_s1_fit;
    logic [RES_W-1:0] r_rd_a, r_rd_b;
    logic r_out_vld;
    logic [RES_W-1:0] r_out;

    logic in_acc, sweep, clearing, idx_zero, fit;
    logic [IW-1:0] addr_b, cap_idx, wr_addr;
    logic [CMP_W-1:0] cap_cmp;
    logic [RES_W:0] sum;
    logic [RES_W-1:0] take, upd, wr_data;
    logic wr_en, cap_hit, cfg_wr;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (idx_zero) n_state = ST_IDLE;
            ST_IDLE:  if (in_acc) n_state = ST_SWEEP;
            ST_SWEEP: if (idx_zero) n_state = ST_DRAIN;
            ST_DRAIN: n_state = ST_IDLE;
            default:  n_state = ST_CLEAR;
        endcase
    end

    // State outputs
    always_comb begin
        o_in_stall = 1'b1;
        sweep = 1'b0;
        clearing = 1'b0;
        unique case (r_state)
            ST_CLEAR: clearing = 1'b1;
            ST_IDLE:  o_in_stall = r_out_vld && i_last_item;
            ST_SWEEP: sweep = 1'b1;
            ST_DRAIN: ;
            default:  ;
        endcase
    end

    assign in_acc = i_in_valid && !o_in_stall;
    assign idx_zero = (r_idx == '0);

    // Stage 0: address generation
    assign fit = ({1'b0, r_w} <= {{(CMP_W-IW){1'b0}}, r_idx});
    assign addr_b = fit ? (r_idx - r_w[IW-1:0]) : r_idx;

    // Stage 1: saturating add, compare, write back
    assign sum = {1'b0, r_rd_b} + {{(RES_W+1-VAL_W){1'b0}}, r_v};
    assign take = sum[RES_W] ? '1 : sum[RES_W-1:0];
    assign upd = (r_s1_fit && (take > r_rd_a)) ? take : r_rd_a;

    assign cap_cmp = ({{(CMP_W-CAP_W){1'b0}}, r_cap} > MAX_CMP) ? MAX_CMP
                   : {{(CMP_W-CAP_W){1'b0}}, r_cap};
    assign cap_idx = cap_cmp[IW-1:0];
    assign cap_hit = r_s1_vld && r_last && (r_s1_idx == cap_idx);

    // Write-back: the updated value, or zero while clearing and on the last item of a set
    always_comb begin
        wr_en = r_s1_vld || clearing;
        wr_addr = clearing ? r_idx : r_s1_idx;
        wr_data = (clearing || r_last) ? '0 : upd;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_a <= mem[r_idx];
        r_rd_b <= mem[addr_b];
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_idx <= MAX_IDX;
            r_s1_vld <= 1'b0;
            r_out_vld <= 1'b0;
            r_cap <= '0;
        end else begin
            r_state <= n_state;
            r_s1_vld <= sweep;
            if (in_acc) begin
                r_idx <= MAX_IDX;
            end else if ((sweep || clearing) && !idx_zero) begin
                r_idx <= r_idx - IW'(1);
            end
            if (cap_hit) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            if (cfg_wr && (paddr[2] == REG_CAPACITY)) begin
                r_cap <= pwdata[CAP_W-1:0];
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_w <= i_item_weight;
            r_v <= i_item_value;
            r_last <= i_last_item;
        end
        r_s1_idx <= r_idx;
        r_s1_fit <= fit;
        if (cap_hit) begin
            r_out <= upd;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_best_value = r_out;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_CAPACITY) ? {{(DATA_W-CAP_W){1'b0}}, r_cap} : '0;

endmodule

[rtl/core/knap_chk.sv]
// Port-level checker for the knapsack solver, bound to knapsack_01_best_value.
// Depends on knap_pkg.
module knap_chk (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_stall,
    input logic                       o_out_valid,
    input logic                       i_out_stall,
    input logic [knap_pkg::RES_W-1:0] o_best_value
);
    import knap_pkg::*;

    // A held result keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_best_value))
        else $error("result changed while stalled");

    // An accepted request starts a sweep, so the next one waits
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("request accepted during a sweep");

    // Reset starts the clearing pass with no result pending
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall && !o_out_valid)
        else $error("input open or result pending after reset");

    // A result appears only out of a running sweep
    a_result_from_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without a sweep");

endmodule

bind knapsack_01_best_value knap_chk u_knap_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_best_value (o_best_value)
);

[sim/testbench.sv]
// Self-checking testbench of the 0/1 knapsack best-value solver.
// Depends on knap_pkg and knapsack_01_best_value; a scoreboard class holds the row prediction.
`timescale 1ns / 1ps

import knap_pkg::*;

class best_value_board #(int TOP = 1023);
    logic [RES_W-1:0] row [0:TOP];
    logic [CAP_W-1:0] cap;
    logic [RES_W-1:0] expected_best [$];
    int errors;

    function new();
        clear_row();
        cap = '0;
        errors = 0;
    endfunction

    function void clear_row();
        for (int j = 0; j <= TOP; j++) row[j] = '0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] c);
        cap = c;
    endfunction

    function int pending();
        return expected_best.size();
    endfunction

    // Sweep the row top-down so that every item is taken at most once.
    function void take_item(logic [WGT_W-1:0] w, logic [VAL_W-1:0] v, logic last);
        logic [RES_W:0] sum;
        int c;
        for (int j = TOP; j >= 0; j--) begin
            if (int'(w) <= j) begin
                sum = {1'b0, row[j - int'(w)]} + {{(RES_W + 1 - VAL_W){1'b0}}, v};
                if (sum[RES_W]) sum[RES_W-1:0] = '1;
                if (sum[RES_W-1:0] > row[j]) row[j] = sum[RES_W-1:0];
            end
        end
        if (last) begin
            c = (int'(cap) > TOP) ? TOP : int'(cap);
            expected_best.push_back(row[c]);
            clear_row();
        end
    endfunction

    function void check_best(logic [RES_W-1:0] got);
        logic [RES_W-1:0] want;
        if (expected_best.size() == 0) begin
            $display("%0t: unexpected best_value: expected none, got %0d", $time, got);
            errors++;
        end else begin
            want = expected_best.pop_front();
            if (got !== want) begin
                $display("%0t: best_value mismatch: expected %0d, got %0d", $time, want, got);
                errors++;
            end
        end
    endfunction
endclass

module testbench;

    localparam int MAX_CAPACITY = 1023;
    localparam int SWEEP_LAT = MAX_CAPACITY + 20;
    localparam int HOLD_CYCLES = 5000;
    localparam int PHASE_ITEMS = 70;
    localparam logic REG_UNUSED = 1'b1;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [WGT_W-1:0]    i_item_weight;
    logic [VAL_W-1:0]    i_item_value;
    logic                i_last_item;
    logic                o_out_valid;
    logic                i_out_stall;
    logic [RES_W-1:0]    o_best_value;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    best_value_board #(MAX_CAPACITY) board;

    logic hold_rx;
    logic calm;
    logic rx_stalling;
    int   rx_run_left;

    knapsack_01_best_value #(
        .MAX_CAPACITY(MAX_CAPACITY)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_item_weight (i_item_weight),
        .i_item_value  (i_item_value),
        .i_last_item   (i_last_item),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_best_value  (o_best_value),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    initial begin
        #100_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Most gaps are short, a few long enough to land anywhere in a sweep.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(0, 3);
        if (r < 96) return $urandom_range(4, 30);
        return $urandom_range(200, 1500);
    endfunction

    function automatic logic [WGT_W-1:0] rand_weight(logic [CAP_W-1:0] c);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return WGT_W'($urandom_range(0, c));
            6:       return '0;
            7:       return WGT_W'($urandom_range(0, MAX_CAPACITY));
            8:       return WGT_W'($urandom);
            default: return WGT_W'($urandom_range(int'(c) + 1, 65535));
        endcase
    endfunction

    function automatic logic [VAL_W-1:0] rand_value();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '1;
        if (r == 1) return VAL_W'($urandom_range(0, 3));
        return VAL_W'($urandom);
    endfunction

    // Receiver: random stall runs, a long hold-off on request, none while calm.
    initial begin
        i_out_stall = 1'b0;
        rx_stalling = 1'b0;
        rx_run_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_rx) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_rx = 1'b0;
                rx_stalling = 1'b0;
                rx_run_left = 0;
                i_out_stall <= 1'b0;
            end else if (calm) begin
                i_out_stall <= 1'b0;
            end else begin
                if (rx_run_left == 0) begin
                    rx_stalling = !rx_stalling;
                    if (rx_stalling) rx_run_left = pick_gap() + 1;
                    else if ($urandom_range(0, 19) == 0) rx_run_left = $urandom_range(1000, 4000);
                    else rx_run_left = $urandom_range(1, 40);
                end
                rx_run_left--;
                i_out_stall <= rx_stalling;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) board.check_best(o_best_value);
    end

    task automatic idle_gap(input int gap);
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic send_item(input logic [WGT_W-1:0] w, input logic [VAL_W-1:0] v,
                             input logic last);
        @(negedge i_clk);
        i_in_valid    <= 1'b1;
        i_item_weight <= w;
        i_item_value  <= v;
        i_last_item   <= last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        board.take_item(w, v, last);
        idle_gap(calm ? 0 : pick_gap());
    endtask

    // Hold off until every result is out and any open sweep has finished.
    task automatic settle();
        idle_gap(1);
        while (board.pending() != 0) @(posedge i_clk);
        repeat (SWEEP_LAT) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic idx, input logic [DATA_W-1:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (idx == REG_CAPACITY) board.set_capacity(data[CAP_W-1:0]);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic reg_read_check();
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {REG_CAPACITY, 2'b00};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== {{(DATA_W - CAP_W){1'b0}}, board.cap}) begin
            $display("%0t: capacity readback mismatch: expected %0d, got %0d",
                     $time, board.cap, prdata);
            board.errors++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic configure(input logic [CAP_W-1:0] c);
        logic [DATA_W-1:0] data;
        settle();
        if ($urandom_range(0, 1)) reg_write(REG_UNUSED, $urandom);
        data = $urandom;
        data[CAP_W-1:0] = c;
        reg_write(REG_CAPACITY, data);
        reg_read_check();
    endtask

    // Mostly well-formed short sets, some noise items with a random last flag.
    task automatic run_phase(input int n_items);
        int sent;
        int len;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 9) == 0) begin
                send_item(rand_weight(board.cap), rand_value(), 1'($urandom_range(0, 1)));
                sent++;
            end else begin
                len = $urandom_range(1, 6);
                for (int k = 0; k < len; k++) begin
                    send_item(rand_weight(board.cap), rand_value(), k == len - 1);
                    sent++;
                end
            end
        end
        // Leave the set open at times so that the next capacity applies mid-set.
        if ($urandom_range(0, 1)) send_item(rand_weight(board.cap), rand_value(), 1'b0);
    endtask

    initial begin
        logic [CAP_W-1:0] cap_plan [8];
        board         = new();
        hold_rx       = 1'b0;
        calm          = 1'b0;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_item_weight = '0;
        i_item_value  = '0;
        i_last_item   = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        reg_read_check();

        // Capacity zero: zero weight is taken, anything heavier never fits.
        send_item(16'd0, 16'hFFFF, 1'b1);
        send_item(16'd1, 16'd9, 1'b1);
        send_item(16'hFFFF, 16'hFFFF, 1'b0);
        send_item(16'd0, 16'd0, 1'b1);

        configure(10'd1023);
        send_item(16'd1023, 16'd100, 1'b0);
        send_item(16'd1024, 16'd7, 1'b0);
        send_item(16'd512, 16'd60, 1'b0);
        send_item(16'd511, 16'd50, 1'b1);
        send_item(16'd0, 16'd1, 1'b0);
        send_item(16'd0, 16'd2, 1'b0);
        send_item(16'd1023, 16'hFFFF, 1'b1);
        send_item(16'd1, 16'hFFFF, 1'b0);
        send_item(16'd1, 16'hFFFF, 1'b0);
        send_item(16'd1, 16'hFFFF, 1'b1);
        send_item(16'h8000, 16'hFFFF, 1'b1);

        // Change capacity in the middle of a set.
        send_item(16'd5, 16'd10, 1'b0);
        send_item(16'd3, 16'd4, 1'b0);
        configure(10'd7);
        send_item(16'd4, 16'd5, 1'b1);

        cap_plan[0] = 10'd1023;
        cap_plan[1] = 10'd0;
        cap_plan[2] = 10'd1;
        cap_plan[3] = CAP_W'($urandom);
        cap_plan[4] = 10'd1023;
        cap_plan[5] = CAP_W'($urandom_range(1, 40));
        cap_plan[6] = CAP_W'($urandom);
        cap_plan[7] = 10'd1023;
        for (int p = 0; p < 8; p++) begin
            configure(cap_plan[p]);
            if (p == 4) hold_rx = 1'b1;
            calm = (p == 7);
            run_phase(PHASE_ITEMS);
        end

        settle();
        if (board.errors == 0 && board.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
